@@ hdl/srip_pkg.sv @@
// Shared types and constants for the integral-preserving spectral rebinner.
`timescale 1ns / 1ps
package srip_pkg;

  localparam int unsigned EDGE_W     = 48;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned TAG_W      = 2;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned SHELL_W    = 3;
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned SHELLS_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BINS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BINS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHELL_COUNT = 2'd2;

  localparam logic [TAG_W-1:0] TAG_INVALID_MIN = 2'd2;

  typedef enum logic [1:0] {
    OP_SRC_EDGE  = 2'd0,
    OP_SRC_LEVEL = 2'd1,
    OP_TGT_EDGE  = 2'd2,
    OP_COMPUTE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_CELL  = 2'd1,
    STS_BAD_COVER = 2'd2,
    STS_BAD_SHELL = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [SHELL_W-1:0] shell;
    logic [INDEX_W-1:0] index;
    logic [EDGE_W-1:0]  edge_req;
    logic [LEVEL_W-1:0] level;
    logic [TAG_W-1:0]   validity;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mean_level;
    logic [1:0]         status;
  } out_word_t;

endpackage

@@ hdl/srip_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module srip_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/srip_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module srip_div
  import srip_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = 88
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [EDGE_W-1:0]     divisor_i,
  output logic                  done_o,
  output logic [LEVEL_W-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] num_q;
  logic [EDGE_W-1:0]     den_q;
  logic [EDGE_W-1:0]     rem_q;
  logic [LEVEL_W-1:0]    quo_q;
  logic [EDGE_W:0]       trial;
  logic [EDGE_W:0]       diff;
  logic                  fits;

  assign trial = {rem_q, num_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
      rem_q <= fits ? diff[EDGE_W-1:0] : trial[EDGE_W-1:0];
      quo_q <= {quo_q[LEVEL_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/spectral_rebin_integral_preserving.sv @@
// Top level: stores, walk sequencer, shared multiply-accumulate and divider.
// Load words pass through the emit state to the output register; one word in flight at a time.
// Compute words read both target edges, walk the source edges from the cursor, multiply and
// accumulate each overlapping bin, then wait on the serial divider before the emit state.
// Reset clears control, configuration (all 1) and the cursor; stores need no clear.
`timescale 1ns / 1ps
module spectral_rebin_integral_preserving
  import srip_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_BINS = 256,
  parameter int unsigned MAX_TARGET_BINS = 256,
  parameter int unsigned MAX_SHELLS      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW     = $clog2(MAX_SOURCE_BINS + 1);
  localparam int unsigned TEA_W  = $clog2(MAX_TARGET_BINS + 1);
  localparam int unsigned LA_W   = $clog2(MAX_SHELLS * MAX_SOURCE_BINS);
  localparam int unsigned ACC_W  = 80 + $clog2(MAX_SOURCE_BINS);
  localparam int unsigned COV_W  = EDGE_W + $clog2(MAX_SOURCE_BINS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_LO, S_RD_HI, S_CUR_CHK, S_WALK_RD, S_WALK_CMP, S_SUM_START,
    S_SUM_LOAD0, S_SUM_TEST, S_SUM_EDGE1, S_MUL_LO, S_MUL_HI, S_ACC_HI,
    S_FINAL, S_DIV_WAIT, S_EMIT
  } state_e;

  state_e              state_q;
  logic [CFG_DATA_W-1:0] source_bins_q;
  logic [CFG_DATA_W-1:0] target_bins_q;
  logic [SHELLS_W-1:0] shell_count_q;
  logic [CW-1:0]       cursor_q;
  logic [CW-1:0]       k_q;
  logic [SHELL_W-1:0]  shell_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [EDGE_W-1:0]   lo_q;
  logic [EDGE_W-1:0]   hi_q;
  logic [EDGE_W-1:0]   e0_q;
  logic [EDGE_W-1:0]   ov_q;
  logic [LEVEL_W-1:0]  lv_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]    acc_q;
  logic [COV_W-1:0]    cov_q;
  logic [LEVEL_W-1:0]  res_mean_q;
  logic [1:0]          res_status_q;
  logic                out_valid_q;
  out_word_t           out_data_q;

  logic                accept;
  logic [CW-1:0]       n_c;
  logic                shell_bad;
  logic                tidx_bad;
  logic                se_we;
  logic                te_we;
  logic                lv_we;
  logic [CW-1:0]       se_raddr;
  logic [TEA_W-1:0]    te_raddr;
  logic [LA_W-1:0]     lv_raddr;
  logic [LA_W-1:0]     lv_waddr;
  logic [EDGE_W-1:0]   se_rdata;
  logic [EDGE_W-1:0]   te_rdata;
  logic [TAG_W+LEVEL_W-1:0] lv_rdata;
  logic [EDGE_W-1:0]   left;
  logic [EDGE_W-1:0]   right;
  logic [LEVEL_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_out;
  logic [ACC_W-1:0]    acc_add;
  logic [ACC_W-1:0]    acc_sum;
  logic                div_start;
  logic                div_done;
  logic [LEVEL_W-1:0]  div_quo;
  logic                out_free;
  logic                emit_fire;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_fire   = (state_q == S_EMIT) && out_free;

  always_comb begin
    int unsigned ns;
    int unsigned nt;
    ns = (32'(shell_count_q) > MAX_SHELLS) ? MAX_SHELLS : 32'(shell_count_q);
    nt = (32'(target_bins_q) > MAX_TARGET_BINS) ? MAX_TARGET_BINS : 32'(target_bins_q);
    n_c = (32'(source_bins_q) > MAX_SOURCE_BINS) ? CW'(MAX_SOURCE_BINS)
                                                 : CW'(source_bins_q);
    shell_bad = 32'(in_data_i.shell) >= ns;
    tidx_bad  = 32'(in_data_i.index) >= nt;
  end

  assign se_we = accept && (in_data_i.op == OP_SRC_EDGE) &&
                 (32'(in_data_i.index) <= MAX_SOURCE_BINS);
  assign te_we = accept && (in_data_i.op == OP_TGT_EDGE) &&
                 (32'(in_data_i.index) <= MAX_TARGET_BINS);
  assign lv_we = accept && (in_data_i.op == OP_SRC_LEVEL) &&
                 (32'(in_data_i.shell) < MAX_SHELLS) &&
                 (32'(in_data_i.index) < MAX_SOURCE_BINS);
  assign lv_waddr = LA_W'(32'(in_data_i.shell) * MAX_SOURCE_BINS + 32'(in_data_i.index));
  assign lv_raddr = LA_W'(32'(shell_q) * MAX_SOURCE_BINS + 32'(k_q));

  always_comb begin
    se_raddr = '0;
    te_raddr = '0;
    case (state_q)
      S_IDLE:      te_raddr = TEA_W'(in_data_i.index);
      S_RD_LO:     te_raddr = TEA_W'(idx_q + INDEX_W'(1));
      S_RD_HI:     se_raddr = cursor_q;
      S_WALK_RD:   se_raddr = k_q + CW'(1);
      S_SUM_START: se_raddr = k_q;
      S_SUM_TEST:  se_raddr = k_q + CW'(1);
      default:     se_raddr = '0;
    endcase
  end

  srip_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_SOURCE_BINS + 1)) u_src_edges (
    .clk_i   (clk_i),
    .we_i    (se_we),
    .waddr_i (CW'(in_data_i.index)),
    .wdata_i (in_data_i.edge_req),
    .raddr_i (se_raddr),
    .rdata_o (se_rdata)
  );

  srip_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_TARGET_BINS + 1)) u_tgt_edges (
    .clk_i   (clk_i),
    .we_i    (te_we),
    .waddr_i (TEA_W'(in_data_i.index)),
    .wdata_i (in_data_i.edge_req),
    .raddr_i (te_raddr),
    .rdata_o (te_rdata)
  );

  srip_ram #(.WIDTH(TAG_W + LEVEL_W), .DEPTH(MAX_SHELLS * MAX_SOURCE_BINS)) u_levels (
    .clk_i   (clk_i),
    .we_i    (lv_we),
    .waddr_i (lv_waddr),
    .wdata_i ({in_data_i.validity, in_data_i.level}),
    .raddr_i (lv_raddr),
    .rdata_o (lv_rdata)
  );

  assign left    = (e0_q > lo_q) ? e0_q : lo_q;
  assign right   = (se_rdata < hi_q) ? se_rdata : hi_q;
  assign mul_b   = (state_q == S_MUL_LO) ? ov_q[LEVEL_W-1:0] : LEVEL_W'(ov_q[EDGE_W-1:32]);
  assign mul_out = {{(PROD_W-LEVEL_W){1'b0}}, lv_q} * {{(PROD_W-LEVEL_W){1'b0}}, mul_b};
  assign acc_add = (state_q == S_ACC_HI) ? ACC_W'({prod_q, 32'b0}) : ACC_W'(prod_q);
  assign acc_sum = acc_q + acc_add;
  assign div_start = (state_q == S_FINAL) && (hi_q > lo_q) &&
                     (cov_q == COV_W'(hi_q - lo_q));

  srip_div #(.DIVIDEND_W(ACC_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (hi_q - lo_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_bins_q <= CFG_DATA_W'(1);
      target_bins_q <= CFG_DATA_W'(1);
      shell_count_q <= SHELLS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SOURCE_BINS: source_bins_q <= cfg_data_i;
        CFG_TARGET_BINS: target_bins_q <= cfg_data_i;
        CFG_SHELL_COUNT: shell_count_q <= cfg_data_i[SHELLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            shell_q      <= in_data_i.shell;
            idx_q        <= in_data_i.index;
            res_mean_q   <= '0;
            res_status_q <= STS_OK;
            if (in_data_i.op != OP_COMPUTE) begin
              state_q <= S_EMIT;
            end else if (shell_bad) begin
              res_status_q <= STS_BAD_SHELL;
              state_q      <= S_EMIT;
            end else if (tidx_bad) begin
              res_status_q <= STS_BAD_COVER;
              state_q      <= S_EMIT;
            end else begin
              state_q <= S_RD_LO;
            end
          end
        end
        S_RD_LO: begin
          lo_q    <= te_rdata;
          state_q <= S_RD_HI;
        end
        S_RD_HI: begin
          hi_q <= te_rdata;
          if (idx_q == '0 || cursor_q > n_c || cursor_q == '0) begin
            k_q     <= '0;
            state_q <= S_WALK_RD;
          end else begin
            k_q     <= cursor_q;
            state_q <= S_CUR_CHK;
          end
        end
        S_CUR_CHK: begin
          if (lo_q < se_rdata) begin
            k_q <= '0;
          end
          state_q <= S_WALK_RD;
        end
        S_WALK_RD: begin
          if (k_q < n_c) begin
            state_q <= S_WALK_CMP;
          end else begin
            cursor_q <= k_q;
            state_q  <= S_SUM_START;
          end
        end
        S_WALK_CMP: begin
          if (se_rdata <= lo_q) begin
            k_q     <= k_q + CW'(1);
            state_q <= S_WALK_RD;
          end else begin
            cursor_q <= k_q;
            state_q  <= S_SUM_START;
          end
        end
        S_SUM_START: begin
          acc_q   <= '0;
          cov_q   <= '0;
          state_q <= (k_q < n_c) ? S_SUM_LOAD0 : S_FINAL;
        end
        S_SUM_LOAD0: begin
          e0_q    <= se_rdata;
          state_q <= S_SUM_TEST;
        end
        S_SUM_TEST: begin
          state_q <= (k_q < n_c && e0_q < hi_q) ? S_SUM_EDGE1 : S_FINAL;
        end
        S_SUM_EDGE1: begin
          e0_q <= se_rdata;
          if (right > left) begin
            if (lv_rdata[TAG_W+LEVEL_W-1:LEVEL_W] >= TAG_INVALID_MIN) begin
              res_status_q <= STS_BAD_CELL;
              state_q      <= S_EMIT;
            end else begin
              ov_q    <= right - left;
              lv_q    <= lv_rdata[LEVEL_W-1:0];
              state_q <= S_MUL_LO;
            end
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_SUM_TEST;
          end
        end
        S_MUL_LO: begin
          prod_q  <= mul_out;
          state_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc_q   <= acc_sum;
          prod_q  <= mul_out;
          state_q <= S_ACC_HI;
        end
        S_ACC_HI: begin
          acc_q   <= acc_sum;
          cov_q   <= cov_q + COV_W'(ov_q);
          k_q     <= k_q + CW'(1);
          state_q <= S_SUM_TEST;
        end
        S_FINAL: begin
          if (div_start) begin
            state_q <= S_DIV_WAIT;
          end else begin
            res_status_q <= STS_BAD_COVER;
            state_q      <= S_EMIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_mean_q <= div_quo;
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_q.mean_level <= res_mean_q;
            out_data_q.status     <= res_status_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_word_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("output word raised outside emit");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STS_OK || out_data_o.mean_level == '0))
    else $error("nonzero level with error status");

  a_covered_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_WAIT) |-> (cov_q == COV_W'(hi_q - lo_q) && hi_q > lo_q))
    else $error("division started without exact coverage");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM_START) |-> (cursor_q == k_q && k_q <= n_c))
    else $error("cursor out of step with walk");

endmodule

@@ tb/sv/spectral_rebin_integral_preserving_tb.sv @@
// Testbench for the spectral rebinner: directed table, then random phases against a predictor.
`timescale 1ns / 1ps
module spectral_rebin_integral_preserving_tb;
  import srip_pkg::*;

  localparam logic [EDGE_W-1:0] EDGE_TOP = '1;
  localparam int unsigned SRC_DEPTH = 256;
  localparam int unsigned TGT_DEPTH = 256;
  localparam int unsigned SHELL_DEPTH = 8;
  localparam int unsigned PHASES = 8;
  localparam int unsigned RAND_PER_PHASE = 20;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SOURCE_BINS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  spectral_rebin_integral_preserving dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [EDGE_W-1:0] src_edge [0:SRC_DEPTH];
  logic [EDGE_W-1:0] tgt_edge [0:TGT_DEPTH];
  logic [33:0]       level_cell [0:SHELL_DEPTH*SRC_DEPTH-1];
  bit                cell_set [0:SHELL_DEPTH*SRC_DEPTH-1];
  int unsigned       walk_cursor = 0;
  int unsigned       reg_src = 1, reg_tgt = 1, reg_shells = 1;

  out_word_t   rebinned_q[$];
  int unsigned n_err = 0;
  int unsigned src_idle = 0, rx_stall = 0;
  dir_row_t    dir_tab[25];

  function automatic int unsigned clamp_cap(int unsigned v, int unsigned cap);
    return v > cap ? cap : v;
  endfunction

  function automatic out_word_t rebin_word(in_word_t w);
    int unsigned n, nt, ns, q, k, idx, base;
    logic [EDGE_W-1:0] lo, hi, left, right, ov;
    logic [127:0] integral, covered;
    logic [33:0] c;
    out_word_t r;
    r = '0;
    idx = w.index;
    base = int'(w.shell) * SRC_DEPTH;
    case (op_e'(w.op))
      OP_SRC_EDGE: if (idx <= SRC_DEPTH) src_edge[idx] = w.edge_req;
      OP_SRC_LEVEL: if (idx < SRC_DEPTH) begin
        level_cell[base + idx] = {w.validity, w.level};
        cell_set[base + idx] = 1'b1;
      end
      OP_TGT_EDGE: if (idx <= TGT_DEPTH) tgt_edge[idx] = w.edge_req;
      default: begin
        n = clamp_cap(reg_src, SRC_DEPTH);
        nt = clamp_cap(reg_tgt, TGT_DEPTH);
        ns = clamp_cap(reg_shells, SHELL_DEPTH);
        if (w.shell >= ns) begin
          r.status = STS_BAD_SHELL;
        end else if (idx >= nt) begin
          r.status = STS_BAD_COVER;
        end else begin
          lo = tgt_edge[idx];
          hi = tgt_edge[idx + 1];
          q = walk_cursor;
          if (idx == 0 || q > n) q = 0;
          else if (q > 0 && lo < src_edge[q]) q = 0;
          while (q < n && src_edge[q + 1] <= lo) q++;
          walk_cursor = q;
          integral = '0;
          covered = '0;
          r.status = STS_OK;
          for (k = q; k < n && src_edge[k] < hi; k++) begin
            left = src_edge[k] > lo ? src_edge[k] : lo;
            right = src_edge[k + 1] < hi ? src_edge[k + 1] : hi;
            if (right > left) begin
              c = level_cell[base + k];
              ov = right - left;
              if (c[33:32] >= TAG_INVALID_MIN) begin
                r.status = STS_BAD_CELL;
                break;
              end
              integral += 128'(c[31:0]) * 128'(ov);
              covered += 128'(ov);
            end
          end
          if (r.status == STS_OK) begin
            if (hi <= lo || covered != 128'(hi - lo)) r.status = STS_BAD_COVER;
            else r.mean_level = 32'(integral / 128'(hi - lo));
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_word_t mk_word(op_e op, int unsigned sh, int unsigned idx,
                                       logic [EDGE_W-1:0] e, logic [LEVEL_W-1:0] lv,
                                       logic [TAG_W-1:0] tag);
    in_word_t w;
    w.op = op;
    w.shell = sh[SHELL_W-1:0];
    w.index = idx[INDEX_W-1:0];
    w.edge_req = e;
    w.level = lv;
    w.validity = tag;
    return w;
  endfunction

  function automatic logic [EDGE_W-1:0] rand_edge();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[EDGE_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 14) return 2'd0;
    if (r < 17) return 2'd1;
    return TAG_W'($urandom_range(2, 3));
  endfunction

  function automatic dir_row_t row(in_word_t w, bit typed, logic [LEVEL_W-1:0] mean,
                                   status_e st);
    dir_row_t d;
    d.word = w;
    d.typed = typed;
    d.want.mean_level = mean;
    d.want.status = st;
    return d;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t pred;
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = rebin_word(w);
    rebinned_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rebinned_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned s, input int unsigned t, input int unsigned h);
    int unsigned v [3];
    v = '{s, t, h};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i <= v[i][CFG_DATA_W-1:0];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (CFG_IDX_W'(i))
        CFG_SOURCE_BINS: reg_src = v[i] & 9'h1FF;
        CFG_TARGET_BINS: reg_tgt = v[i] & 9'h1FF;
        default:         reg_shells = v[i] & 4'hF;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_phase();
    int unsigned n, nt, ns, shift;
    logic [EDGE_W-1:0] e, first;
    logic [63:0] span, t;
    out_word_t none;
    none = '0;
    n = clamp_cap(reg_src, SRC_DEPTH);
    nt = clamp_cap(reg_tgt, TGT_DEPTH);
    ns = clamp_cap(reg_shells, SHELL_DEPTH);
    shift = 10 + 17 * $urandom_range(0, 2);
    first = EDGE_W'($urandom_range(0, 1 << 20));
    e = first;
    for (int unsigned i = 0; i <= n; i++) begin
      if (i > 0) e = e + 1 + (rand_edge() >> shift);
      send_word(mk_word(OP_SRC_EDGE, 0, i, e, 0, 0), 1'b0, none);
    end
    span = 64'(e - first);
    for (int unsigned j = 0; j <= nt; j++) begin
      t = 64'(first) + span * j / nt;
      if (j == nt) t = ($urandom_range(7) == 0) ? 64'(e) + 1 : 64'(e);
      send_word(mk_word(OP_TGT_EDGE, 0, j, t[EDGE_W-1:0], 0, 0), 1'b0, none);
    end
    for (int unsigned s = 0; s < ns; s++)
      for (int unsigned b = 0; b < n; b++)
        if (!cell_set[s * SRC_DEPTH + b])
          send_word(mk_word(OP_SRC_LEVEL, s, b, 0, $urandom, rand_tag()), 1'b0, none);
  endtask

  task automatic random_phase();
    int unsigned n, nt, ns, roll, sh, idx, m, last_bin;
    logic [EDGE_W-1:0] lo, hi, v;
    in_word_t w;
    out_word_t none;
    bit on_src;
    none = '0;
    last_bin = 0;
    n = clamp_cap(reg_src, SRC_DEPTH);
    nt = clamp_cap(reg_tgt, TGT_DEPTH);
    ns = clamp_cap(reg_shells, SHELL_DEPTH);
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        sh = (ns > 0 && $urandom_range(9) != 0) ? $urandom_range(0, ns - 1) : $urandom_range(7);
        roll = $urandom_range(99);
        if (roll < 50) idx = (last_bin + 1) % (nt > 0 ? nt : 1);
        else if (roll < 85) idx = $urandom_range(0, nt > 0 ? nt - 1 : 0);
        else idx = $urandom_range(0, 511);
        last_bin = idx;
        w = mk_word(OP_COMPUTE, sh, idx, rand_edge(), $urandom, TAG_W'($urandom));
      end else if (roll < 70) begin
        idx = ($urandom_range(4) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 511);
        w = mk_word(OP_SRC_LEVEL, $urandom_range(7), idx, rand_edge(), $urandom, rand_tag());
      end else if (roll < 90) begin
        on_src = $urandom_range(1);
        m = on_src ? n : nt;
        idx = $urandom_range(0, m);
        v = on_src ? src_edge[idx] : tgt_edge[idx];
        if (idx > 0 && idx < m) begin
          lo = on_src ? src_edge[idx - 1] : tgt_edge[idx - 1];
          hi = on_src ? src_edge[idx + 1] : tgt_edge[idx + 1];
          if (hi > lo && hi - lo >= 2) v = lo + 1 + rand_edge() % (hi - lo - 1);
        end
        w = mk_word(on_src ? OP_SRC_EDGE : OP_TGT_EDGE, $urandom_range(7), idx, v, $urandom,
                    TAG_W'($urandom));
      end else begin
        w = mk_word(op_e'($urandom_range(3)), $urandom_range(7), $urandom_range(0, 511),
                    rand_edge(), $urandom, TAG_W'($urandom));
      end
      send_word(w, 1'b0, none);
    end
  endtask

  always @(posedge clk_i) begin : rx_check
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rebinned_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word: mean %h status %0d",
                                  out_data_o.mean_level, out_data_o.status);
      end else begin
        want = rebinned_q.pop_front();
        if (out_data_o.mean_level !== want.mean_level || out_data_o.status !== want.status) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: mean exp %h got %h, status exp %0d got %0d",
                     want.mean_level, out_data_o.mean_level, want.status, out_data_o.status);
        end
      end
    end
    out_stall_i <= (rx_stall > 0) && ($urandom_range(99) < rx_stall);
  end

  initial begin
    int unsigned ph_src [PHASES];
    int unsigned ph_tgt [PHASES];
    int unsigned ph_sh  [PHASES];
    ph_src = '{4, 16, 8, 2, 511, 2, 0, 1};
    ph_tgt = '{4, 8, 4, 1, 511, 2, 2, 1};
    ph_sh  = '{2, 3, 1, 8, 1, 15, 2, 1};
    dir_tab[0]  = row(mk_word(OP_SRC_EDGE, 0, 0, 0, 0, 0), 1, 0, STS_OK);
    dir_tab[1]  = row(mk_word(OP_SRC_EDGE, 7, 1, EDGE_TOP, '1, 3), 1, 0, STS_OK);
    dir_tab[2]  = row(mk_word(OP_SRC_LEVEL, 0, 0, 0, 32'hFFFF_FFFF, 0), 1, 0, STS_OK);
    dir_tab[3]  = row(mk_word(OP_TGT_EDGE, 0, 0, 0, 0, 0), 1, 0, STS_OK);
    dir_tab[4]  = row(mk_word(OP_TGT_EDGE, 0, 1, EDGE_TOP, 0, 0), 1, 0, STS_OK);
    dir_tab[5]  = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 32'hFFFF_FFFF, STS_OK);
    dir_tab[6]  = row(mk_word(OP_COMPUTE, 1, 0, 0, 0, 0), 1, 0, STS_BAD_SHELL);
    dir_tab[7]  = row(mk_word(OP_COMPUTE, 0, 1, 0, 0, 0), 1, 0, STS_BAD_COVER);
    dir_tab[8]  = row(mk_word(OP_SRC_LEVEL, 0, 0, 0, 32'h0001_2345, 1), 1, 0, STS_OK);
    dir_tab[9]  = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 32'h0001_2345, STS_OK);
    dir_tab[10] = row(mk_word(OP_SRC_LEVEL, 0, 0, 0, 32'h0000_FFFF, 2), 1, 0, STS_OK);
    dir_tab[11] = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 0, STS_BAD_CELL);
    dir_tab[12] = row(mk_word(OP_SRC_LEVEL, 0, 0, 0, 32'h0000_FFFF, 3), 1, 0, STS_OK);
    dir_tab[13] = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 0, STS_BAD_CELL);
    dir_tab[14] = row(mk_word(OP_SRC_LEVEL, 0, 0, 0, 32'h0001_0000, 0), 1, 0, STS_OK);
    dir_tab[15] = row(mk_word(OP_TGT_EDGE, 0, 1, 0, 0, 0), 1, 0, STS_OK);
    dir_tab[16] = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 0, STS_BAD_COVER);
    dir_tab[17] = row(mk_word(OP_TGT_EDGE, 0, 1, EDGE_TOP, 0, 0), 1, 0, STS_OK);
    dir_tab[18] = row(mk_word(OP_SRC_EDGE, 0, 0, 1, 0, 0), 1, 0, STS_OK);
    dir_tab[19] = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 0, STS_BAD_COVER);
    dir_tab[20] = row(mk_word(OP_SRC_EDGE, 0, 511, 48'hAAAA_5555_AAAA, 0, 0), 1, 0, STS_OK);
    dir_tab[21] = row(mk_word(OP_SRC_LEVEL, 7, 300, 0, 32'h5555_AAAA, 3), 1, 0, STS_OK);
    dir_tab[22] = row(mk_word(OP_TGT_EDGE, 0, 257, EDGE_TOP, 0, 0), 1, 0, STS_OK);
    dir_tab[23] = row(mk_word(OP_SRC_EDGE, 0, 0, 0, 0, 0), 1, 0, STS_OK);
    dir_tab[24] = row(mk_word(OP_COMPUTE, 0, 0, 0, 0, 0), 1, 32'h0001_0000, STS_OK);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle = 26;
    rx_stall = 50;
    foreach (dir_tab[i]) send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        src_idle = 26;
        rx_stall = 50;
      end else if (p < 6) begin
        src_idle = 50;
        rx_stall = 26;
      end else begin
        src_idle = 0;
        rx_stall = 0;
      end
      set_config(ph_src[p], ph_tgt[p], ph_sh[p]);
      load_phase();
      random_phase();
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (n_err == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
